// ===== design/vt4_pkg.sv =====
// shared types and constants for the 4x4 vertex transform
package vt4_pkg;

  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int HALF_W    = 32;
  localparam int FIELD_W   = 32;

  typedef struct packed {
    logic                       command;
    logic signed [FIELD_W-1:0]  in_x;
    logic signed [FIELD_W-1:0]  in_y;
    logic signed [FIELD_W-1:0]  in_z;
    logic signed [FIELD_W-1:0]  in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0]  out_x;
    logic signed [FIELD_W-1:0]  out_y;
    logic signed [FIELD_W-1:0]  out_z;
    logic signed [FIELD_W-1:0]  out_w;
    logic                       clipped;
  } out_item_t;

  // travels alongside the lane pipeline
  typedef struct packed {
    logic valid;
    logic affine;
  } vt4_ctrl_t;

endpackage

// ===== design/vertex_transform_4x4_top.sv =====
// top level of the 4x4 matrix-vector transform: config regs, input stage, lanes
//
//  channel   signals                      handshake
//  -------   --------------------------   ----------------------------------
//  input     cmd (in_item_t)              start high and busy low at a clk edge
//  output    result (out_item_t)          done high for one cycle per item
//  config    cfg_index, cfg_data          cfg_we high at a clk edge
//
// an item is accepted every cycle while busy is low; its result passes through
// the input register, the multiplier stage, two adder stages, the saturation stage
// in each row lane and the output register of the merge
// busy is high during reset and up to the first clk edge after it
// reset restores the identity matrix
// the receiver cannot stall, so done is a one-cycle strobe
module vertex_transform_4x4_top #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  vt4_pkg::in_item_t               cmd,
  output logic                            done,
  output vt4_pkg::out_item_t              result,
  input  logic                            cfg_we,
  input  logic [vt4_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [vt4_pkg::REG_W-1:0]       cfg_data
);

  localparam int VEC_WIDTH = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 2;
  localparam int LANE_LAT  = 4;
  localparam int LATENCY   = LANE_LAT + 2;

  localparam logic [vt4_pkg::REG_W-1:0] ONE_LO = vt4_pkg::REG_W'(1) << FRAC_BITS;
  localparam logic [vt4_pkg::REG_W-1:0] ONE_HI = ONE_LO << vt4_pkg::HALF_W;
  localparam logic signed [VEC_WIDTH-1:0] ONE_VEC = VEC_WIDTH'(1) << FRAC_BITS;

  localparam logic signed [vt4_pkg::FIELD_W-1:0] OUT_MAX =
    vt4_pkg::FIELD_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [vt4_pkg::FIELD_W-1:0] OUT_MIN = ~OUT_MAX;

  // identity value of one register: the diagonal coefficient sits in the half
  // whose column matches the register's row
  function automatic logic [vt4_pkg::REG_W-1:0] ident_reg(input int idx);
    int row;
    row = idx >> 1;
    if ((row >> 1) == (idx & 1)) begin
      return ((row & 1) != 0) ? ONE_HI : ONE_LO;
    end
    return '0;
  endfunction

  logic [vt4_pkg::REG_W-1:0]      mregs [vt4_pkg::NUM_REGS];
  logic                           accept;
  logic signed [VEC_WIDTH-1:0]    vec   [vt4_pkg::NUM_COLS];
  vt4_pkg::vt4_ctrl_t             ctrl  [LANE_LAT+1];
  logic signed [DATA_WIDTH-1:0]   coef  [vt4_pkg::NUM_ROWS][vt4_pkg::NUM_COLS];
  logic signed [DATA_WIDTH-1:0]   row_val [vt4_pkg::NUM_ROWS];
  logic                           sat     [vt4_pkg::NUM_ROWS];

  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      for (int i = 0; i < vt4_pkg::NUM_REGS; i++) begin
        mregs[i] <= ident_reg(i);
      end
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        mregs[cfg_index] <= cfg_data;
      end
    end
  end

  // input stage: narrow to DATA_WIDTH, sign extend to VEC_WIDTH, affine w = one
  always_ff @(posedge clk) begin
    if (accept) begin
      vec[0] <= VEC_WIDTH'(signed'(cmd.in_x[DATA_WIDTH-1:0]));
      vec[1] <= VEC_WIDTH'(signed'(cmd.in_y[DATA_WIDTH-1:0]));
      vec[2] <= VEC_WIDTH'(signed'(cmd.in_z[DATA_WIDTH-1:0]));
      vec[3] <= cmd.command ? ONE_VEC : VEC_WIDTH'(signed'(cmd.in_w[DATA_WIDTH-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= LANE_LAT; s++) begin
        ctrl[s] <= '0;
      end
    end else begin
      ctrl[0].valid  <= accept;
      ctrl[0].affine <= cmd.command;
      for (int s = 1; s <= LANE_LAT; s++) begin
        ctrl[s] <= ctrl[s-1];
      end
    end
  end

  for (genvar r = 0; r < vt4_pkg::NUM_ROWS; r++) begin : g_row
    for (genvar c = 0; c < vt4_pkg::NUM_COLS; c++) begin : g_col
      assign coef[r][c] = signed'(
        mregs[r*2 + c/2][(c%2)*vt4_pkg::HALF_W +: DATA_WIDTH]);
    end

    vt4_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .VEC_WIDTH  (VEC_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .coef    (coef[r]),
      .vec     (vec),
      .row_val (row_val[r]),
      .sat     (sat[r])
    );
  end

  vt4_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl[LANE_LAT]),
    .row_val (row_val),
    .sat     (sat),
    .done    (done),
    .result  (result)
  );

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted item");

  a_item_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item produced no result");

  a_affine_w_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(accept && cmd.command, LATENCY)) |-> (result.out_w == '0))
    else $error("affine item returned nonzero w");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    (done && result.clipped) |->
      (result.out_x == OUT_MAX || result.out_x == OUT_MIN ||
       result.out_y == OUT_MAX || result.out_y == OUT_MIN ||
       result.out_z == OUT_MAX || result.out_z == OUT_MIN ||
       result.out_w == OUT_MAX || result.out_w == OUT_MIN))
    else $error("clip flag set with no component at a bound");

endmodule

// ===== design/vt4_lane.sv =====
// one row lane: four multipliers, adder tree, shift and saturate
module vt4_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int VEC_WIDTH  = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic signed [DATA_WIDTH-1:0] coef [vt4_pkg::NUM_COLS],
  input  logic signed [VEC_WIDTH-1:0]  vec  [vt4_pkg::NUM_COLS],
  output logic signed [DATA_WIDTH-1:0] row_val,
  output logic                         sat
);

  localparam int PROD_W = DATA_WIDTH + VEC_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [PROD_W-1:0] prod [vt4_pkg::NUM_COLS];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    for (int c = 0; c < vt4_pkg::NUM_COLS; c++) begin
      prod[c] <= PROD_W'(coef[c]) * PROD_W'(vec[c]);
    end
    pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
    pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    total   <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
  end

  // arithmetic shift floors, matching truncation toward minus infinity
  assign shifted = total >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (shifted > SAT_HI) begin
      row_val <= SAT_HI[DATA_WIDTH-1:0];
      sat     <= 1'b1;
    end else if (shifted < SAT_LO) begin
      row_val <= SAT_LO[DATA_WIDTH-1:0];
      sat     <= 1'b1;
    end else begin
      row_val <= shifted[DATA_WIDTH-1:0];
      sat     <= 1'b0;
    end
  end

endmodule

// ===== design/vt4_merge.sv =====
// merges the four lane results into one output item with a clip flag
module vt4_merge #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vt4_pkg::vt4_ctrl_t           ctrl,
  input  logic signed [DATA_WIDTH-1:0] row_val [vt4_pkg::NUM_ROWS],
  input  logic                         sat     [vt4_pkg::NUM_ROWS],
  output logic                         done,
  output vt4_pkg::out_item_t           result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
  end

  // affine mode drops row 3 from both the result and the flag
  always_ff @(posedge clk) begin
    result.out_x   <= vt4_pkg::FIELD_W'(row_val[0]);
    result.out_y   <= vt4_pkg::FIELD_W'(row_val[1]);
    result.out_z   <= vt4_pkg::FIELD_W'(row_val[2]);
    result.out_w   <= ctrl.affine ? '0 : vt4_pkg::FIELD_W'(row_val[3]);
    result.clipped <= sat[0] | sat[1] | sat[2] | (sat[3] & ~ctrl.affine);
  end

endmodule
